[rtl/sscc_pkg.sv]
// package: types, constants and helpers for the sun sensor chebyshev calibration
package sscc_pkg;

  localparam int unsigned MaxTermsDef = 6;
  localparam int unsigned CoeffSlots = 6;
  localparam int unsigned RawW = 16;
  localparam int unsigned XW = 20;
  localparam int unsigned QW = 36;
  localparam int unsigned CoefW = 20;
  localparam int unsigned AccW = 32;
  localparam int unsigned CntW = 3;
  localparam int unsigned CosW = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 20;
  localparam logic [XW-1:0] XMax = '1;
  localparam logic signed [AccW-1:0] OneQ16 = 32'sd65536;

  typedef enum logic [CfgIdxW-1:0] {
    RegFullScale = 3'd0,
    RegTermCount = 3'd1,
    RegCoeff0 = 3'd2,
    RegCoeff1 = 3'd3,
    RegCoeff2 = 3'd4,
    RegCoeff3 = 3'd5,
    RegCoeff4 = 3'd6,
    RegCoeff5 = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [RawW-1:0] raw_sample;
    logic frame_end;
  } in_item_t;

  typedef struct packed {
    logic [CosW-1:0] cos_value;
    logic frame_last;
  } out_item_t;

  typedef struct packed {
    logic [RawW-1:0] full_scale;
    logic [CntW-1:0] term_count;
  } cfg_t;

  function automatic logic signed [AccW-1:0] sat32(input logic signed [55:0] v);
    logic signed [55:0] hi;
    logic signed [55:0] lo;
    hi = 56'sd2147483647;
    lo = -56'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[AccW-1:0];
  endfunction

endpackage

[rtl/sun_sensor_chebyshev_calibrate.sv]
// top level: sun sensor normalize and chebyshev correction pipeline
//  channel | handshake           | payload
//  input   | start_i, busy_o     | item_i (in_item_t)
//  config  | cfg_valid_i/ready_o | cfg_index_i, cfg_data_i
//  result  | done_o strobe       | item_o (out_item_t)
// one item per cycle; 9 divider stages plus 2*MaxTerms term stages
// busy_o is always low, the pipeline never stalls; reset clears valid bits
// and loads full_scale 65535, term_count 0, coefficients 0
module sun_sensor_chebyshev_calibrate
  import sscc_pkg::*;
#(
  parameter int unsigned MaxTerms = MaxTermsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  in_item_t item_i,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic done_o,
  output out_item_t item_o
);

  cfg_t cfg_q;
  logic signed [CoefW-1:0] coeff_q [CoeffSlots];
  logic dv;
  logic df;
  logic [XW-1:0] dx;

  assign busy_o = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_scale <= 16'hffff;
      cfg_q.term_count <= '0;
      for (int i = 0; i < CoeffSlots; i++) coeff_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegFullScale: cfg_q.full_scale <= cfg_data_i[RawW-1:0];
        RegTermCount: cfg_q.term_count <= cfg_data_i[CntW-1:0];
        RegCoeff0: coeff_q[0] <= cfg_data_i;
        RegCoeff1: coeff_q[1] <= cfg_data_i;
        RegCoeff2: coeff_q[2] <= cfg_data_i;
        RegCoeff3: coeff_q[3] <= cfg_data_i;
        RegCoeff4: coeff_q[4] <= cfg_data_i;
        RegCoeff5: coeff_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sscc_div u_div (
    .clk_i, .rst_ni,
    .valid_i(start_i), .raw_i(item_i.raw_sample), .frame_i(item_i.frame_end),
    .div_i(cfg_q.full_scale),
    .valid_o(dv), .x_o(dx), .frame_o(df)
  );

  sscc_cheb #(.MaxTerms(MaxTerms)) u_cheb (
    .clk_i, .rst_ni,
    .valid_i(dv), .x_i(dx), .frame_i(df),
    .n_i(cfg_q.term_count), .coeff_i(coeff_q),
    .valid_o(done_o), .item_o
  );

endmodule

[rtl/sscc_div.sv]
// pipelined restoring divider: x = floor(raw * 65536 / full_scale), saturated
module sscc_div
  import sscc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  logic [RawW-1:0] raw_i,
  input  logic frame_i,
  input  logic [RawW-1:0] div_i,
  output logic valid_o,
  output logic [XW-1:0] x_o,
  output logic frame_o
);

  localparam int unsigned Steps = QW;
  localparam int unsigned PerStage = 4;
  localparam int unsigned Stages = Steps / PerStage;

  logic [Stages:0] v_q;
  logic [Stages:0] f_q;
  logic [QW-1:0] n_q [Stages+1];
  logic [QW-1:0] q_q [Stages+1];
  logic [RawW:0] r_q [Stages+1];
  logic [RawW-1:0] d_q [Stages+1];

  always_comb begin
    v_q[0] = valid_i;
    f_q[0] = frame_i;
    n_q[0] = {4'd0, raw_i, 16'd0};
    q_q[0] = '0;
    r_q[0] = '0;
    d_q[0] = div_i;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_st
    logic [QW-1:0] n_d;
    logic [QW-1:0] q_d;
    logic [RawW:0] r_d;
    always_comb begin
      logic [RawW+1:0] t;
      n_d = n_q[s];
      q_d = q_q[s];
      r_d = r_q[s];
      for (int i = 0; i < PerStage; i++) begin
        t = {r_d, n_d[QW-1]};
        n_d = {n_d[QW-2:0], 1'b0};
        if (t >= {2'b00, d_q[s]}) begin
          t = t - {2'b00, d_q[s]};
          q_d = {q_d[QW-2:0], 1'b1};
        end else begin
          q_d = {q_d[QW-2:0], 1'b0};
        end
        r_d = t[RawW:0];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      f_q[s+1] <= f_q[s];
      n_q[s+1] <= n_d;
      q_q[s+1] <= q_d;
      r_q[s+1] <= r_d;
      d_q[s+1] <= d_q[s];
    end
  end

  assign valid_o = v_q[Stages];
  assign frame_o = f_q[Stages];
  assign x_o = (d_q[Stages] == '0 || q_q[Stages][QW-1:XW] != '0) ? XMax
             : q_q[Stages][XW-1:0];

endmodule

[rtl/sscc_cheb.sv]
// chebyshev recurrence and correction sum, two register stages per term
module sscc_cheb
  import sscc_pkg::*;
#(
  parameter int unsigned MaxTerms = MaxTermsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  logic [XW-1:0] x_i,
  input  logic frame_i,
  input  logic [CntW-1:0] n_i,
  input  logic signed [CoefW-1:0] coeff_i [CoeffSlots],
  output logic valid_o,
  output out_item_t item_o
);

  localparam int unsigned L = MaxTerms + 1;

  logic [L-1:0] v_q;
  logic [L-1:0] f_q;
  logic [XW-1:0] x_q [L];
  logic signed [AccW-1:0] tp_q [L];
  logic signed [AccW-1:0] tn_q [L];
  logic signed [AccW-1:0] s_q [L];
  logic signed [55:0] pc_q [MaxTerms];
  logic signed [55:0] pt_q [MaxTerms];
  logic [MaxTerms-1:0] m_v_q;
  logic [MaxTerms-1:0] m_f_q;
  logic [XW-1:0] m_x_q [MaxTerms];
  logic signed [AccW-1:0] m_tp_q [MaxTerms];
  logic signed [AccW-1:0] m_tn_q [MaxTerms];
  logic signed [AccW-1:0] m_s_q [MaxTerms];
  logic [CntW-1:0] n_eff;

  assign n_eff = (n_i > CntW'(MaxTerms)) ? CntW'(MaxTerms) : n_i;

  always_comb begin
    v_q[0] = valid_i;
    f_q[0] = frame_i;
    x_q[0] = x_i;
    tp_q[0] = OneQ16;
    tn_q[0] = OneQ16;
    s_q[0] = '0;
  end

  for (genvar k = 0; k < MaxTerms; k++) begin : g_term
    logic signed [AccW-1:0] t_use;
    always_comb begin
      t_use = (k < 2) ? ((k == 0) ? OneQ16 : $signed({12'd0, x_q[k]})) : tn_q[k];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        m_v_q[k] <= 1'b0;
        v_q[k+1] <= 1'b0;
      end else begin
        m_v_q[k] <= v_q[k];
        v_q[k+1] <= m_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      m_f_q[k] <= f_q[k];
      m_x_q[k] <= x_q[k];
      m_tp_q[k] <= (k < 2) ? OneQ16 : tp_q[k];
      m_tn_q[k] <= t_use;
      m_s_q[k] <= s_q[k];
      pc_q[k] <= 56'(coeff_i[k]) * 56'(t_use);
      pt_q[k] <= 56'($signed({1'b0, x_q[k], 1'b0})) * 56'(t_use);
    end
    always_ff @(posedge clk_i) begin
      logic signed [AccW-1:0] term;
      logic signed [AccW-1:0] tnext;
      term = sat32(pc_q[k] >>> 16);
      tnext = sat32((pt_q[k] >>> 16) - 56'(m_tp_q[k]));
      f_q[k+1] <= m_f_q[k];
      x_q[k+1] <= m_x_q[k];
      s_q[k+1] <= (CntW'(k) < n_eff) ? sat32(56'(m_s_q[k]) + 56'(term)) : m_s_q[k];
      if (k == 0) begin
        tp_q[k+1] <= OneQ16;
        tn_q[k+1] <= OneQ16;
      end else begin
        tp_q[k+1] <= m_tn_q[k];
        tn_q[k+1] <= tnext;
      end
    end
  end

  logic signed [AccW-1:0] res;
  assign res = sat32(56'($signed({12'd0, x_q[MaxTerms]})) + 56'(s_q[MaxTerms]));
  assign valid_o = v_q[MaxTerms];
  assign item_o.frame_last = f_q[MaxTerms];
  assign item_o.cos_value = (res > OneQ16) ? CosW'(OneQ16)
                          : (res < 0) ? '0 : res[CosW-1:0];

endmodule
